// File: design/pcc_pkg.sv
package pcc_pkg;

    // Channel widths and pipeline geometry
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned CL_W       = 16;
    localparam int unsigned NUM_W      = 25;
    localparam int unsigned PROD_W     = 33;
    localparam int unsigned DIV_STAGES = 8;
    localparam int unsigned TINT_STAGES = 4;
    localparam int unsigned OVER_STAGES = 2;
    localparam int unsigned STAGES     = DIV_STAGES + TINT_STAGES + OVER_STAGES;

    // Channel positions inside a pixel
    localparam int unsigned CH_R = 0;
    localparam int unsigned CH_G = 1;
    localparam int unsigned CH_B = 2;
    localparam int unsigned CH_A = 3;

    // Colorize product at or above 256 * 128 * 255 saturates
    localparam logic [PROD_W-1:0] SAT_LIMIT = 33'd8355840;

    typedef enum logic [1:0] {
        MODE_COPY      = 2'd0,
        MODE_OVER      = 2'd1,
        MODE_TINT_COPY = 2'd2,
        MODE_TINT_OVER = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_MODE       = 2'd0,
        CFG_TINT_RED   = 2'd1,
        CFG_TINT_GREEN = 2'd2,
        CFG_TINT_BLUE  = 2'd3
    } cfg_index_t;

    typedef logic [3:0][PIX_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t src;
        pixel_t dst;
    } pixel_pair_t;

    // Floor of x / 255 for x below 65280: estimate by x/256 * 257/256, fix once
    function automatic logic [PIX_W-1:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        logic [8:0]  q0;
        logic [16:0] rem;
        sum = {1'b0, x} + {9'd0, x[15:8]};
        q0  = sum[16:8];
        rem = {1'b0, x} - ({q0, 8'd0} - {8'd0, q0});
        return (rem >= 17'd255) ? (q0[7:0] + 8'd1) : q0[7:0];
    endfunction

endpackage

// File: design/pcc_cl_divider.sv
module pcc_cl_divider (
    input  logic                                 clk,
    input  logic [pcc_pkg::DIV_STAGES-1:0]       en,
    input  logic [pcc_pkg::PIX_W-1:0]            red,
    input  logic [pcc_pkg::PIX_W-1:0]            alpha,
    output logic [pcc_pkg::CL_W-1:0]             cl
);

    typedef struct packed {
        logic [7:0]  rem;
        logic [15:0] dvd;
        logic [15:0] quo;
        logic [7:0]  dvs;
    } div_state_t;

    div_state_t st_reg  [pcc_pkg::DIV_STAGES];
    div_state_t st_next [pcc_pkg::DIV_STAGES];
    div_state_t st_init;

    // Two restoring quotient bits per stage
    function automatic div_state_t div_step(input div_state_t s);
        div_state_t t;
        logic [8:0] r9;
        t = s;
        for (int b = 0; b < 2; b++)
        begin
            r9    = {t.rem, t.dvd[15]};
            t.dvd = {t.dvd[14:0], 1'b0};
            if (r9 >= {1'b0, t.dvs})
            begin
                r9    = r9 - {1'b0, t.dvs};
                t.quo = {t.quo[14:0], 1'b1};
            end
            else
            begin
                t.quo = {t.quo[14:0], 1'b0};
            end
            t.rem = r9[7:0];
        end
        return t;
    endfunction

    // Dividend is red * 255
    always_comb
    begin
        st_init.rem = '0;
        st_init.dvd = {red, 8'd0} - {8'd0, red};
        st_init.quo = '0;
        st_init.dvs = alpha;
    end

    for (genvar k = 0; k < pcc_pkg::DIV_STAGES; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            assign st_next[k] = div_step(st_init);
        end
        else
        begin : g_rest
            assign st_next[k] = div_step(st_reg[k-1]);
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // Zero alpha gives zero luminance
    assign cl = (st_reg[pcc_pkg::DIV_STAGES-1].dvs == 8'd0) ? '0
                : st_reg[pcc_pkg::DIV_STAGES-1].quo;

endmodule

// File: design/pcc_tint_lane.sv
module pcc_tint_lane (
    input  logic                                 clk,
    input  logic [pcc_pkg::TINT_STAGES-1:0]      en,
    input  logic [pcc_pkg::PIX_W-1:0]            tint,
    input  logic [pcc_pkg::CL_W-1:0]             cl,
    input  logic [pcc_pkg::PIX_W-1:0]            alpha,
    output logic [pcc_pkg::PIX_W-1:0]            color
);

    logic                         bright;
    logic [7:0]                   mul_a;
    logic [15:0]                  mul_b;
    logic [23:0]                  mul_p;
    logic [pcc_pkg::NUM_W-1:0]    num_next;
    logic [pcc_pkg::NUM_W-1:0]    num_reg;
    logic [7:0]                   alpha_reg;
    logic [pcc_pkg::PROD_W-1:0]   prod_next;
    logic [pcc_pkg::PROD_W-1:0]   prod_reg;
    logic                         sat_reg;
    logic [15:0]                  x_reg;
    logic [7:0]                   color_reg;

    // Pick bright or dark curve and form the numerator
    always_comb
    begin
        bright   = (cl > 16'd128);
        mul_a    = bright ? (8'd255 - tint) : tint;
        mul_b    = bright ? (cl - 16'd128) : cl;
        mul_p    = {16'd0, mul_a} * {8'd0, mul_b};
        num_next = {1'b0, mul_p} + (bright ? {10'd0, tint, 7'd0} : '0);
    end

    // Scale by alpha
    assign prod_next = {8'd0, num_reg} * {25'd0, alpha_reg};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            num_reg   <= num_next;
            alpha_reg <= alpha;
        end
        if (en[1])
        begin
            prod_reg <= prod_next;
        end
        // Split off saturation, drop the divide by 128
        if (en[2])
        begin
            sat_reg <= (prod_reg >= pcc_pkg::SAT_LIMIT);
            x_reg   <= prod_reg[22:7];
        end
        if (en[3])
        begin
            color_reg <= sat_reg ? 8'hFF : pcc_pkg::div255(x_reg);
        end
    end

    assign color = color_reg;

endmodule

// File: design/pcc_over_lane.sv
module pcc_over_lane (
    input  logic                                 clk,
    input  logic [pcc_pkg::OVER_STAGES-1:0]      en,
    input  logic                                 blend,
    input  logic [pcc_pkg::PIX_W-1:0]            src,
    input  logic [pcc_pkg::PIX_W-1:0]            alpha,
    input  logic [pcc_pkg::PIX_W-1:0]            dst,
    output logic [pcc_pkg::PIX_W-1:0]            pix
);

    logic [7:0]  s_reg;
    logic        blend_reg;
    logic [15:0] prod_next;
    logic [15:0] prod_reg;
    logic [7:0]  q;
    logic [8:0]  sum;
    logic [7:0]  pix_next;
    logic [7:0]  pix_reg;

    // Weight the destination by the uncovered fraction
    assign prod_next = {8'd0, 8'd255 - alpha} * {8'd0, dst};

    // Add and saturate, or pass the source through
    always_comb
    begin
        q        = pcc_pkg::div255(prod_reg);
        sum      = {1'b0, s_reg} + {1'b0, q};
        pix_next = blend_reg ? (sum[8] ? 8'hFF : sum[7:0]) : s_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s_reg     <= src;
            blend_reg <= blend;
            prod_reg  <= prod_next;
        end
        if (en[1])
        begin
            pix_reg <= pix_next;
        end
    end

    assign pix = pix_reg;

endmodule

// File: design/premultiplied_pixel_compositor_unit.sv
// An accepted input word passes the divider, colorize and over stages to its
// output word. Unless the output stalls, the 8-stage luminance divider, the
// 4-stage colorize lanes and 2-stage over lanes take a new word every cycle.
// A stalled output holds only the stages that are full; bubbles still collapse.
// Reset clears all stage valids, sets mode to blend over and the tint to black.
module premultiplied_pixel_compositor_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  src_red,
    input  logic [7:0]  src_green,
    input  logic [7:0]  src_blue,
    input  logic [7:0]  src_alpha,
    input  logic [7:0]  dst_red,
    input  logic [7:0]  dst_green,
    input  logic [7:0]  dst_blue,
    input  logic [7:0]  dst_alpha,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_alpha
);

    localparam int unsigned STAGES = pcc_pkg::STAGES;
    localparam int unsigned SIDE_N = pcc_pkg::DIV_STAGES + pcc_pkg::TINT_STAGES;
    localparam int unsigned TINT_LO = pcc_pkg::DIV_STAGES;
    localparam int unsigned OVER_LO = SIDE_N;

    pcc_pkg::mode_t              mode_reg;
    logic [7:0]                  tint_reg [3];

    logic [STAGES-1:0]           v_reg;
    logic [STAGES-1:0]           v_next;
    logic [STAGES-1:0]           ready;
    logic [STAGES-1:0]           en;

    pcc_pkg::pixel_pair_t        in_pair;
    pcc_pkg::pixel_pair_t        side_reg [SIDE_N];

    logic [pcc_pkg::CL_W-1:0]    cl;
    pcc_pkg::pixel_t             tint_pix;
    pcc_pkg::pixel_t             col_pix;
    pcc_pkg::pixel_t             out_pix;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= pcc_pkg::MODE_OVER;
            tint_reg[0] <= '0;
            tint_reg[1] <= '0;
            tint_reg[2] <= '0;
        end
        else if (cfg_write)
        begin
            case (pcc_pkg::cfg_index_t'(cfg_index))
                pcc_pkg::CFG_MODE:       mode_reg    <= pcc_pkg::mode_t'(cfg_data[1:0]);
                pcc_pkg::CFG_TINT_RED:   tint_reg[0] <= cfg_data;
                pcc_pkg::CFG_TINT_GREEN: tint_reg[1] <= cfg_data;
                pcc_pkg::CFG_TINT_BLUE:  tint_reg[2] <= cfg_data;
                default:                 mode_reg    <= mode_reg;
            endcase
        end
    end

    // Elastic pipeline control: a stage advances when it is empty or the next moves
    always_comb
    begin
        ready[STAGES-1] = !v_reg[STAGES-1] || !out_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            ready[k] = !v_reg[k] || ready[k+1];
        end
        for (int k = 0; k < STAGES; k++)
        begin
            if (k == 0)
            begin
                v_next[k] = ready[k] ? in_valid : v_reg[k];
                en[k]     = ready[k] && in_valid;
            end
            else
            begin
                v_next[k] = ready[k] ? v_reg[k-1] : v_reg[k];
                en[k]     = ready[k] && v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall  = !ready[0];
    assign out_valid = v_reg[STAGES-1];

    // Gather input word
    always_comb
    begin
        in_pair.src[pcc_pkg::CH_R] = src_red;
        in_pair.src[pcc_pkg::CH_G] = src_green;
        in_pair.src[pcc_pkg::CH_B] = src_blue;
        in_pair.src[pcc_pkg::CH_A] = src_alpha;
        in_pair.dst[pcc_pkg::CH_R] = dst_red;
        in_pair.dst[pcc_pkg::CH_G] = dst_green;
        in_pair.dst[pcc_pkg::CH_B] = dst_blue;
        in_pair.dst[pcc_pkg::CH_A] = dst_alpha;
    end

    // Carry the raw pixels alongside the divider and tint lanes
    for (genvar k = 0; k < SIDE_N; k++)
    begin : g_side
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    side_reg[k] <= in_pair;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    // Luminance cl = red * 255 / alpha
    pcc_cl_divider u_div (
        .clk   (clk),
        .en    (en[pcc_pkg::DIV_STAGES-1:0]),
        .red   (src_red),
        .alpha (src_alpha),
        .cl    (cl)
    );

    // One colorize lane per color channel
    for (genvar c = 0; c < 3; c++)
    begin : g_tint
        pcc_tint_lane u_lane (
            .clk   (clk),
            .en    (en[TINT_LO +: pcc_pkg::TINT_STAGES]),
            .tint  (tint_reg[c]),
            .cl    (cl),
            .alpha (side_reg[TINT_LO-1].src[pcc_pkg::CH_A]),
            .color (tint_pix[c])
        );
    end
    assign tint_pix[pcc_pkg::CH_A] = side_reg[SIDE_N-1].src[pcc_pkg::CH_A];

    // Merge: colorized or raw source; alpha always stays source alpha
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            col_pix[c] = mode_reg[1] ? tint_pix[c] : side_reg[SIDE_N-1].src[c];
        end
    end

    // One over lane per channel
    for (genvar c = 0; c < 4; c++)
    begin : g_over
        pcc_over_lane u_lane (
            .clk   (clk),
            .en    (en[OVER_LO +: pcc_pkg::OVER_STAGES]),
            .blend (mode_reg[0]),
            .src   (col_pix[c]),
            .alpha (side_reg[SIDE_N-1].src[pcc_pkg::CH_A]),
            .dst   (side_reg[SIDE_N-1].dst[c]),
            .pix   (out_pix[c])
        );
    end

    assign out_red   = out_pix[pcc_pkg::CH_R];
    assign out_green = out_pix[pcc_pkg::CH_G];
    assign out_blue  = out_pix[pcc_pkg::CH_B];
    assign out_alpha = out_pix[pcc_pkg::CH_A];

    // An accepted word lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v_reg[0])
    else $error("accepted word did not enter first stage");

    // A full last divider stage that cannot move keeps its word
    assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[TINT_LO-1] && !ready[TINT_LO] |=> v_reg[TINT_LO-1])
    else $error("word dropped at divider output");

    // An empty output stage means the whole pipe can take a word
    assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[STAGES-1] |-> !in_stall)
    else $error("input stalled with empty output stage");

endmodule

// File: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned PHASE_WORDS   = 167;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned DRAIN_CYCLES  = pcc_pkg::STAGES + 10;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       cfg_write = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] src_red   = '0;
    logic [7:0] src_green = '0;
    logic [7:0] src_blue  = '0;
    logic [7:0] src_alpha = '0;
    logic [7:0] dst_red   = '0;
    logic [7:0] dst_green = '0;
    logic [7:0] dst_blue  = '0;
    logic [7:0] dst_alpha = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    // Shadow copy of the configuration registers
    pcc_pkg::mode_t mode_q = pcc_pkg::MODE_OVER;
    logic [7:0]     tint_q [3] = '{8'd0, 8'd0, 8'd0};

    pcc_pkg::pixel_pair_t pending_pairs [$];
    pcc_pkg::pixel_t      expected_pixels [$];
    pcc_pkg::pixel_pair_t driven_pair;
    pcc_pkg::pixel_t      got_pixel;
    pcc_pkg::pixel_t      want_pixel;

    int unsigned in_idle_pct  = 0;
    int unsigned out_idle_pct = 0;
    int unsigned in_gap       = 0;
    int unsigned out_hold     = 0;
    int unsigned mismatches   = 0;
    int unsigned words_in     = 0;
    int unsigned words_out    = 0;
    int unsigned phases       = 0;
    int unsigned cycles       = 0;

    string chan_name [4] = '{"red", "green", "blue", "alpha"};

    premultiplied_pixel_compositor_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .src_red   (src_red),
        .src_green (src_green),
        .src_blue  (src_blue),
        .src_alpha (src_alpha),
        .dst_red   (dst_red),
        .dst_green (dst_green),
        .dst_blue  (dst_blue),
        .dst_alpha (dst_alpha),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [7:0] sat8(input longint unsigned v);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // Two-piece tint curve over the luminance, premultiplied again by alpha
    function automatic logic [7:0] tint_lane(input longint unsigned lum,
                                             input longint unsigned a,
                                             input longint unsigned t);
        longint unsigned num;
        if (lum > 128)
            num = (255 - t) * (lum - 128) + 128 * t;
        else
            num = t * lum;
        return sat8((num * a) / (128 * 255));
    endfunction

    function automatic logic [7:0] blend_over(input longint unsigned s,
                                              input longint unsigned a,
                                              input longint unsigned d);
        return sat8(s + ((255 - a) * d) / 255);
    endfunction

    // Expected destination pixel for one source/destination pair
    function automatic pcc_pkg::pixel_t composite(input pcc_pkg::pixel_pair_t px);
        pcc_pkg::pixel_t s;
        pcc_pkg::pixel_t r;
        longint unsigned a;
        longint unsigned lum;
        s = px.src;
        a = 64'(px.src[pcc_pkg::CH_A]);
        if (mode_q == pcc_pkg::MODE_TINT_COPY || mode_q == pcc_pkg::MODE_TINT_OVER)
        begin
            lum = (a == 0) ? 0 : (64'(px.src[pcc_pkg::CH_R]) * 255) / a;
            for (int k = 0; k < 3; k++)
                s[k] = tint_lane(lum, a, 64'(tint_q[k]));
        end
        if (mode_q == pcc_pkg::MODE_OVER || mode_q == pcc_pkg::MODE_TINT_OVER)
        begin
            for (int k = 0; k < 4; k++)
                r[k] = blend_over(64'(s[k]), a, 64'(px.dst[k]));
        end
        else
            r = s;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap(input int unsigned pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 12);
        return $urandom_range(3, 1);
    endfunction

    function automatic pcc_pkg::pixel_pair_t make_pair(
            input logic [7:0] sr, input logic [7:0] sg,
            input logic [7:0] sb, input logic [7:0] sa,
            input logic [7:0] dr, input logic [7:0] dg,
            input logic [7:0] db, input logic [7:0] da);
        pcc_pkg::pixel_pair_t p;
        p.src = {sa, sb, sg, sr};
        p.dst = {da, db, dg, dr};
        return p;
    endfunction

    // Mostly valid premultiplied sources, some with color above alpha
    function automatic pcc_pkg::pixel_pair_t random_pair();
        pcc_pkg::pixel_pair_t p;
        int unsigned a;
        case ($urandom_range(9))
            0: a = 0;
            1: a = 255;
            default: a = $urandom_range(255);
        endcase
        p.src[pcc_pkg::CH_A] = a[7:0];
        for (int k = 0; k < 3; k++)
            p.src[k] = ($urandom_range(9) < 2) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(a));
        for (int k = 0; k < 4; k++)
            p.dst[k] = 8'($urandom_range(255));
        return p;
    endfunction

    function automatic logic [7:0] pick_tint();
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
        mismatches++;
    endtask

    task automatic write_reg(input pcc_pkg::cfg_index_t idx, input logic [7:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == pcc_pkg::CFG_MODE)
            mode_q = pcc_pkg::mode_t'(val[1:0]);
        else
            tint_q[int'(idx) - 1] = val;
    endtask

    task automatic set_config(input pcc_pkg::mode_t m, input logic [7:0] tr,
                              input logic [7:0] tg, input logic [7:0] tb);
        write_reg(pcc_pkg::CFG_MODE, 8'(m));
        write_reg(pcc_pkg::CFG_TINT_RED, tr);
        write_reg(pcc_pkg::CFG_TINT_GREEN, tg);
        write_reg(pcc_pkg::CFG_TINT_BLUE, tb);
        phases++;
    endtask

    // Hold until every queued word is accepted and every result is back
    task automatic wait_drained();
        while (pending_pairs.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Input driver: predict on acceptance, then load the next word or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_pixels.push_back(composite(driven_pair));
                words_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_pairs.size() > 0)
                begin
                    driven_pair = pending_pairs.pop_front();
                    src_red   <= driven_pair.src[pcc_pkg::CH_R];
                    src_green <= driven_pair.src[pcc_pkg::CH_G];
                    src_blue  <= driven_pair.src[pcc_pkg::CH_B];
                    src_alpha <= driven_pair.src[pcc_pkg::CH_A];
                    dst_red   <= driven_pair.dst[pcc_pkg::CH_R];
                    dst_green <= driven_pair.dst[pcc_pkg::CH_G];
                    dst_blue  <= driven_pair.dst[pcc_pkg::CH_B];
                    dst_alpha <= driven_pair.dst[pcc_pkg::CH_A];
                    in_valid  <= 1'b1;
                    in_gap = pick_gap(in_idle_pct);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: compare each accepted word, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                words_out++;
                got_pixel = {out_alpha, out_blue, out_green, out_red};
                if (expected_pixels.size() == 0)
                    flag_mismatch("unexpected word, red", 0,
                                  32'(got_pixel[pcc_pkg::CH_R]));
                else
                begin
                    want_pixel = expected_pixels.pop_front();
                    for (int k = 0; k < 4; k++)
                        if (got_pixel[k] !== want_pixel[k])
                            flag_mismatch(chan_name[k], 32'(want_pixel[k]),
                                          32'(got_pixel[k]));
                end
            end
            if (out_hold == 0)
                out_hold = pick_gap(out_idle_pct);
            if (out_hold > 0)
            begin
                out_stall <= 1'b1;
                out_hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Stimulus: directed words under every mode, then random phases
    initial
    begin
        pcc_pkg::mode_t m;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 4; i++)
        begin
            m = pcc_pkg::mode_t'(2'(i));
            set_config(m, 8'd255, 8'd0, 8'd128);
            // all zero, all full scale
            pending_pairs.push_back(make_pair(8'd0, 8'd0, 8'd0, 8'd0,
                                              8'd0, 8'd0, 8'd0, 8'd0));
            pending_pairs.push_back(make_pair(8'd255, 8'd255, 8'd255, 8'd255,
                                              8'd255, 8'd255, 8'd255, 8'd255));
            // zero source alpha with color above it: blend saturates
            pending_pairs.push_back(make_pair(8'd200, 8'd90, 8'd255, 8'd0,
                                              8'd255, 8'd255, 8'd255, 8'd255));
            // red far above alpha: luminance well past full scale
            pending_pairs.push_back(make_pair(8'd255, 8'd3, 8'd1, 8'd1,
                                              8'd128, 8'd128, 8'd128, 8'd128));
            // opaque mid tones; luminance right at the curve knee
            pending_pairs.push_back(make_pair(8'd128, 8'd64, 8'd32, 8'd255,
                                              8'd10, 8'd20, 8'd30, 8'd40));
            pending_pairs.push_back(make_pair(8'd129, 8'd200, 8'd7, 8'd255,
                                              8'd250, 8'd5, 8'd99, 8'd1));
            wait_drained();
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            m = pcc_pkg::mode_t'(2'(p % 4));
            if (p == 0)
                set_config(m, 8'd255, 8'd255, 8'd255);
            else if (p == 1)
                set_config(m, 8'd0, 8'd0, 8'd0);
            else
                set_config(m, pick_tint(), pick_tint(), pick_tint());
            // every third phase runs without any idling
            in_idle_pct  = (p % 3 == 0) ? 0 : 10 * $urandom_range(5);
            out_idle_pct = (p % 3 == 0) ? 0 : 10 * $urandom_range(5);
            for (int n = 0; n < PHASE_WORDS; n++)
                pending_pairs.push_back(random_pair());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
            flag_mismatch("words never returned", 0, expected_pixels.size());

        $display("covered %0d words in, %0d out, over %0d settings of mode and tint",
                 words_in, words_out, phases);
        $display("all four modes, tint extremes, zero alpha and color above alpha");
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("tb_top failed");
        $finish;
    end

endmodule
